@@ design/tbeq_pkg.sv @@
// Shared constants, types and register codes of the three-band equaliser.
`default_nettype none

package tbeq_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 20;
  localparam int CHANNELS  = 2;
  localparam int GAIN_W    = 16;
  localparam int BAND_W    = 24;
  localparam int COEF_FRAC = 18;
  localparam int GAIN_FRAC = 12;
  localparam int NUM_BANDS = 3;
  localparam int TERMS     = 5;

  localparam int CH_AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int BAND_IW   = $clog2(NUM_BANDS);
  localparam int TERM_W    = $clog2(TERMS);

  localparam int REG_IDX_W = 3;
  localparam int FF_W      = 3 * COEF_W;
  localparam int FB_W      = 2 * COEF_W;
  localparam int GAINS_W   = NUM_BANDS * GAIN_W;
  localparam int CFG_W     = FF_W;

  // Shared multiplier: coefficient or gain times history, sample or part of the mix
  localparam int OPA_W     = COEF_W;
  localparam int OPB_W     = BAND_W + 1;
  localparam int PROD_W    = OPA_W + OPB_W;
  localparam int ACC_W     = 48;
  localparam int LO_W      = 2 * GAIN_FRAC;
  localparam int TLO_W     = GAIN_W + 1;

  // Operation numbering: filter terms band by band, then gains, then master gain halves
  localparam int OP_GAIN0    = NUM_BANDS * TERMS;
  localparam int OP_MLO      = OP_GAIN0 + NUM_BANDS;
  localparam int OP_MHI      = OP_MLO + 1;
  localparam int OP_W        = $clog2(OP_MHI + 1);
  localparam int BUBBLE_STEP = OP_MLO;
  localparam int LAST_STEP   = OP_MHI + 2;
  localparam int STEP_W      = $clog2(LAST_STEP + 1);

  localparam logic [TERM_W-1:0] TERM_B0 = TERM_W'(0);
  localparam logic [TERM_W-1:0] TERM_B1 = TERM_W'(1);
  localparam logic [TERM_W-1:0] TERM_B2 = TERM_W'(2);
  localparam logic [TERM_W-1:0] TERM_A1 = TERM_W'(3);
  localparam logic [TERM_W-1:0] TERM_A2 = TERM_W'(4);

  localparam logic [REG_IDX_W-1:0] REG_LP_FF  = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_LP_FB  = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_BP_FF  = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_BP_FB  = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_HP_FF  = REG_IDX_W'(4);
  localparam logic [REG_IDX_W-1:0] REG_HP_FB  = REG_IDX_W'(5);
  localparam logic [REG_IDX_W-1:0] REG_GAINS  = REG_IDX_W'(6);
  localparam logic [REG_IDX_W-1:0] REG_MASTER = REG_IDX_W'(7);

  localparam logic [GAIN_W-1:0] MASTER_RST = GAIN_W'(4096);

  typedef struct packed {
    logic [NUM_BANDS-1:0][FF_W-1:0] ff;
    logic [NUM_BANDS-1:0][FB_W-1:0] fb;
    logic [GAINS_W-1:0]             gains;
    logic [GAIN_W-1:0]              master;
  } cfg_t;

  typedef struct packed {
    logic [NUM_BANDS-1:0][BAND_W-1:0] y2;
    logic [NUM_BANDS-1:0][BAND_W-1:0] y1;
    logic [SAMPLE_W-1:0]              x2;
    logic [SAMPLE_W-1:0]              x1;
  } hist_t;

  localparam int HIST_W = $bits(hist_t);

  typedef struct packed {
    logic            accept;
    logic            load;
    logic            issue;
    logic [OP_W-1:0] op;
    logic            adv;
    logic            done;
  } ctrl_t;

endpackage

`default_nettype wire

@@ design/three_band_biquad_equalizer.sv @@
// Three-band biquad equaliser: stream ports, registers, history memory, output register.
//
// Usage: one signed 16-bit sample enters on the slave stream with its channel in tuser;
// one equalised, saturated sample leaves on the master stream with the same channel.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i while idle:
// index 0..5 are the feed-forward and feedback coefficients of the low-, band- and
// high-pass sections, 6 the three band gains, 7 the master gain.
// Each channel's filter histories sit in one memory entry that is read when an item
// is taken, updated in place and written back at the end.
// An item is accepted, its history is read from memory, and it then runs 22 steps:
// 15 filter terms, 3 band gains, one idle step and 2 master-gain halves on the single
// shared multiplier, and a final step that adds the halves and saturates.
// s_axis_tready is high only between items, so no new item is taken while one runs;
// the result reaches m_axis_tvalid in the cycle after the last step.
// Reset clears all coefficients and gains, sets the master gain to 1.0 and marks the
// history of every channel as zero through per-channel valid flags.
// While the receiver stalls the result waits in the output register; a following item
// is still accepted and runs until its last step, where it holds until that register
// is free.
`default_nettype none

module three_band_biquad_equalizer
  import tbeq_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [SAMPLE_W-1:0]  s_axis_tdata,   // [15:0] sample_in
  input  wire logic                 s_axis_tuser,   // [0] channel
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [SAMPLE_W-1:0]       m_axis_tdata,   // [15:0] sample_out
  output logic                      m_axis_tuser,   // [0] channel_out
  input  wire logic                 cfg_we_i,
  input  wire logic [REG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  cfg_t                       cfg_q, cfg_d;
  ctrl_t                      ctrl;
  logic                       out_full;
  logic                       out_valid_q;
  logic [SAMPLE_W-1:0]        out_data_q;
  logic                       out_chan_q;
  logic                       chan_q;
  logic [CH_AW-1:0]           chan_idx, idx_q;
  logic [CHANNELS-1:0]        vld_q;
  logic [HIST_W-1:0]          rdata;
  hist_t                      hist_in, hist_wr;
  logic signed [SAMPLE_W-1:0] result;

  // register decoder
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LP_FF:  cfg_d.ff[0]  = cfg_data_i[FF_W-1:0];
        REG_LP_FB:  cfg_d.fb[0]  = cfg_data_i[FB_W-1:0];
        REG_BP_FF:  cfg_d.ff[1]  = cfg_data_i[FF_W-1:0];
        REG_BP_FB:  cfg_d.fb[1]  = cfg_data_i[FB_W-1:0];
        REG_HP_FF:  cfg_d.ff[2]  = cfg_data_i[FF_W-1:0];
        REG_HP_FB:  cfg_d.fb[2]  = cfg_data_i[FB_W-1:0];
        REG_GAINS:  cfg_d.gains  = cfg_data_i[GAINS_W-1:0];
        REG_MASTER: cfg_d.master = cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ff     <= '0;
      cfg_q.fb     <= '0;
      cfg_q.gains  <= '0;
      cfg_q.master <= MASTER_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign out_full = out_valid_q && !m_axis_tready;
  assign chan_idx = (CHANNELS > 1) ? CH_AW'(s_axis_tuser) : '0;

  tbeq_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .out_full_i (out_full),
    .in_ready_o (s_axis_tready),
    .ctrl_o     (ctrl)
  );

  tbeq_ram #(
    .WIDTH (HIST_W),
    .DEPTH (CHANNELS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl.done),
    .waddr_i (idx_q),
    .wdata_i (hist_wr),
    .re_i    (ctrl.accept),
    .raddr_i (chan_idx),
    .rdata_o (rdata)
  );

  // a channel never written back reads as zero history
  assign hist_in = vld_q[idx_q] ? hist_t'(rdata) : '0;

  tbeq_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .cfg_i    (cfg_q),
    .sample_i ($signed(s_axis_tdata)),
    .hist_i   (hist_in),
    .hist_o   (hist_wr),
    .result_o (result)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl.accept) begin
      chan_q <= s_axis_tuser;
      idx_q  <= chan_idx;
    end
    if (ctrl.done) begin
      out_data_q <= result;
      out_chan_q <= chan_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl.done) begin
        vld_q[idx_q] <= 1'b1;
        out_valid_q  <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_chan_q;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.done |-> !out_full)
    else $error("result loaded while the output register still holds an item");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("new item accepted while one is in progress");

  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.done |=> m_axis_tvalid && (m_axis_tuser == $past(chan_q)))
    else $error("finished item not presented with its channel");
`endif

endmodule

`default_nettype wire

@@ design/tbeq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tbeq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ design/tbeq_seq.sv @@
// Sequencer: item handshake and the step schedule of the shared multiplier.
`default_nettype none

module tbeq_seq
  import tbeq_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic out_full_i,
  output logic      in_ready_o,
  output ctrl_t     ctrl_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              last;
  logic              run;

  always_comb begin
    run          = (state_q == ST_RUN);
    last         = (step_q == STEP_W'(LAST_STEP));
    in_ready_o   = (state_q == ST_IDLE);
    ctrl_o.accept = in_valid_i && in_ready_o;
    ctrl_o.load   = (state_q == ST_LOAD);
    // hold on the final step while the output register is still occupied
    ctrl_o.adv    = run && !(last && out_full_i);
    ctrl_o.issue  = run && !last && (step_q != STEP_W'(BUBBLE_STEP));
    ctrl_o.op     = (step_q < STEP_W'(BUBBLE_STEP)) ? OP_W'(step_q)
                                                    : OP_W'(step_q - STEP_W'(1));
    ctrl_o.done   = ctrl_o.adv && last;

    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (ctrl_o.accept) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_d = ST_RUN;
        step_d  = '0;
      end
      ST_RUN: begin
        if (ctrl_o.adv) begin
          if (last) begin
            state_d = ST_IDLE;
          end else begin
            step_d = step_q + STEP_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

`default_nettype wire

@@ design/tbeq_dp.sv @@
// Datapath: shared multiplier, band accumulator, mix and history update.
`default_nettype none

module tbeq_dp
  import tbeq_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire ctrl_t                      ctrl_i,
  input  wire cfg_t                       cfg_i,
  input  wire logic signed [SAMPLE_W-1:0] sample_i,
  input  wire hist_t                      hist_i,
  output hist_t                           hist_o,
  output logic signed [SAMPLE_W-1:0]      result_o
);

  typedef struct packed {
    logic [BAND_IW-1:0] band;
    logic [TERM_W-1:0]  term;
  } op_dec_t;

  localparam logic signed [ACC_W-1:0] BAND_MAX = ACC_W'(2 ** (BAND_W - 1) - 1);
  localparam logic signed [ACC_W-1:0] BAND_MIN = ~BAND_MAX;
  localparam logic signed [ACC_W-1:0] SAMP_MAX = ACC_W'(2 ** (SAMPLE_W - 1) - 1);
  localparam logic signed [ACC_W-1:0] SAMP_MIN = ~SAMP_MAX;
  localparam logic signed [ACC_W-1:0] BAND_RND = ACC_W'(2 ** (COEF_FRAC - 1));
  localparam logic signed [ACC_W-1:0] MIX_RND  = ACC_W'(2 ** (LO_W - 1));

  function automatic op_dec_t split_op(input logic [OP_W-1:0] op);
    op_dec_t d;
    d.band = '0;
    d.term = TERM_W'(op);
    for (int b = 1; b < NUM_BANDS; b++) begin
      if (op >= OP_W'(b * TERMS)) begin
        d.band = BAND_IW'(b);
        d.term = TERM_W'(op - OP_W'(b * TERMS));
      end
    end
    return d;
  endfunction

  logic signed [SAMPLE_W-1:0] x_q;
  hist_t                      hist_q, hist_d;
  logic signed [PROD_W-1:0]   prod_q, prod;
  logic [OP_W-1:0]            prod_op_q;
  logic                       prod_vld_q;
  logic signed [ACC_W-1:0]    acc_q, acc_d;
  logic signed [ACC_W-1:0]    mix_q, mix_d;
  logic signed [TLO_W-1:0]    tlo_q, tlo_d;

  op_dec_t                    id, pd;
  logic [BAND_IW-1:0]         gi;
  logic signed [OPA_W-1:0]    opa;
  logic signed [OPB_W-1:0]    opb;
  logic signed [ACC_W-1:0]    mix_hi;
  logic signed [ACC_W-1:0]    prod_ext, acc_base, acc_sum, band_rnd, res_sum;
  logic signed [BAND_W-1:0]   band_y;

  // operand selection for the op issued this cycle
  always_comb begin
    id     = split_op(ctrl_i.op);
    gi     = BAND_IW'(ctrl_i.op - OP_W'(OP_GAIN0));
    mix_hi = mix_q >>> LO_W;
    opa    = '0;
    opb    = '0;
    if (ctrl_i.op < OP_W'(OP_GAIN0)) begin
      unique case (id.term)
        TERM_B0: begin
          opa = $signed(cfg_i.ff[id.band][COEF_W-1:0]);
          opb = OPB_W'(x_q);
        end
        TERM_B1: begin
          opa = $signed(cfg_i.ff[id.band][2*COEF_W-1:COEF_W]);
          opb = OPB_W'($signed(hist_q.x1));
        end
        TERM_B2: begin
          opa = $signed(cfg_i.ff[id.band][3*COEF_W-1:2*COEF_W]);
          opb = OPB_W'($signed(hist_q.x2));
        end
        TERM_A1: begin
          opa = $signed(cfg_i.fb[id.band][COEF_W-1:0]);
          opb = OPB_W'($signed(hist_q.y1[id.band]));
        end
        default: begin
          opa = $signed(cfg_i.fb[id.band][2*COEF_W-1:COEF_W]);
          opb = OPB_W'($signed(hist_q.y2[id.band]));
        end
      endcase
    end else if (ctrl_i.op < OP_W'(OP_MLO)) begin
      opa = OPA_W'($signed(cfg_i.gains[gi*GAIN_W +: GAIN_W]));
      opb = OPB_W'($signed(hist_q.y1[gi]));
    end else if (ctrl_i.op == OP_W'(OP_MLO)) begin
      // low part of the mix is unsigned
      opa = OPA_W'($signed(cfg_i.master));
      opb = OPB_W'(mix_q[LO_W-1:0]);
    end else begin
      opa = OPA_W'($signed(cfg_i.master));
      opb = mix_hi[OPB_W-1:0];
    end
    prod = opa * opb;
  end

  // accumulate the product registered in the previous cycle
  always_comb begin
    pd       = split_op(prod_op_q);
    prod_ext = ACC_W'(prod_q);
    acc_base = (pd.term == TERM_B0) ? '0 : acc_q;
    if (pd.term == TERM_A1 || pd.term == TERM_A2) begin
      acc_sum = acc_base - prod_ext;
    end else begin
      acc_sum = acc_base + prod_ext;
    end
    band_rnd = (acc_sum + BAND_RND) >>> COEF_FRAC;
    if (band_rnd > BAND_MAX) begin
      band_y = BAND_MAX[BAND_W-1:0];
    end else if (band_rnd < BAND_MIN) begin
      band_y = BAND_MIN[BAND_W-1:0];
    end else begin
      band_y = band_rnd[BAND_W-1:0];
    end

    acc_d  = acc_q;
    mix_d  = mix_q;
    tlo_d  = tlo_q;
    hist_d = hist_q;
    if (ctrl_i.load) begin
      hist_d = hist_i;
    end
    if (ctrl_i.accept) begin
      mix_d = ACC_W'(sample_i) <<< GAIN_FRAC;
    end
    if (ctrl_i.adv && prod_vld_q) begin
      if (prod_op_q < OP_W'(OP_GAIN0)) begin
        acc_d = acc_sum;
        if (pd.term == TERM_A2) begin
          hist_d.y2[pd.band] = hist_q.y1[pd.band];
          hist_d.y1[pd.band] = band_y;
        end
      end else if (prod_op_q < OP_W'(OP_MLO)) begin
        mix_d = mix_q + prod_ext;
      end else if (prod_op_q == OP_W'(OP_MLO)) begin
        tlo_d = TLO_W'((prod_ext + MIX_RND) >>> LO_W);
      end
    end

    // master gain times high part plus rounded low part
    res_sum = prod_ext + ACC_W'(tlo_q);
    if (res_sum > SAMP_MAX) begin
      result_o = SAMP_MAX[SAMPLE_W-1:0];
    end else if (res_sum < SAMP_MIN) begin
      result_o = SAMP_MIN[SAMPLE_W-1:0];
    end else begin
      result_o = res_sum[SAMPLE_W-1:0];
    end

    hist_o    = hist_q;
    hist_o.x1 = x_q;
    hist_o.x2 = hist_q.x1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else if (ctrl_i.adv) begin
      prod_vld_q <= ctrl_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      x_q <= sample_i;
    end
    if (ctrl_i.issue) begin
      prod_q    <= prod;
      prod_op_q <= ctrl_i.op;
    end
    acc_q  <= acc_d;
    mix_q  <= mix_d;
    tlo_q  <= tlo_d;
    hist_q <= hist_d;
  end

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// Self-checking testbench of the three-band biquad equaliser with its own fixed-point predictor.
module tb;
  import tbeq_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int LONG_HOLD   = 400;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 250;

  typedef enum {SET_TAME, SET_RANDOM, SET_MAX, SET_MIN} setting_e;

  localparam setting_e PHASE_PLAN [PHASES] = '{
    SET_TAME, SET_RANDOM, SET_MAX, SET_TAME, SET_MIN, SET_RANDOM, SET_TAME
  };

  typedef struct packed {
    logic                 wr;     // register write rather than an item
    logic [REG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     val;
    logic [SAMPLE_W-1:0]  smp;
    logic                 ch;
    logic                 typed;  // expected sample given in the row
    logic [SAMPLE_W-1:0]  want;
  } dir_row_t;

  localparam int DIR_N = 35;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // reset settings pass the sample straight through
    '{1'b0, REG_LP_FF,  60'h0, 16'h7FFF, 1'b0, 1'b1, 16'h7FFF},
    '{1'b0, REG_LP_FF,  60'h0, 16'h8000, 1'b1, 1'b1, 16'h8000},
    '{1'b0, REG_LP_FF,  60'h0, 16'h0000, 1'b0, 1'b1, 16'h0000},
    '{1'b0, REG_LP_FF,  60'h0, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF},
    '{1'b0, REG_LP_FF,  60'h0, 16'h0001, 1'b0, 1'b1, 16'h0001},
    '{1'b0, REG_LP_FF,  60'h0, 16'h5555, 1'b1, 1'b1, 16'h5555},
    '{1'b0, REG_LP_FF,  60'h0, 16'hAAAA, 1'b0, 1'b1, 16'hAAAA},
    // largest master gain: saturate both ways, round half up
    '{1'b1, REG_MASTER, 60'h7FFF, 16'h0, 1'b0, 1'b0, 16'h0},
    '{1'b0, REG_LP_FF,  60'h0, 16'h7FFF, 1'b0, 1'b1, 16'h7FFF},
    '{1'b0, REG_LP_FF,  60'h0, 16'h8000, 1'b1, 1'b1, 16'h8000},
    '{1'b0, REG_LP_FF,  60'h0, 16'h0800, 1'b0, 1'b1, 16'h4000},
    // most negative master gain flips the sign
    '{1'b1, REG_MASTER, 60'h8000, 16'h0, 1'b0, 1'b0, 16'h0},
    '{1'b0, REG_LP_FF,  60'h0, 16'h7FFF, 1'b1, 1'b1, 16'h8000},
    '{1'b0, REG_LP_FF,  60'h0, 16'h8000, 1'b0, 1'b1, 16'h7FFF},
    '{1'b1, REG_MASTER, 60'h0, 16'h0, 1'b0, 1'b0, 16'h0},
    '{1'b0, REG_LP_FF,  60'h0, 16'h7FFF, 1'b1, 1'b1, 16'h0000},
    // unstable low-pass, resonant band-pass, second-difference high-pass
    '{1'b1, REG_MASTER, 60'h1000, 16'h0, 1'b0, 1'b0, 16'h0},
    '{1'b1, REG_LP_FF,  60'h7FFFF_80000_7FFFF, 16'h0, 1'b0, 1'b0, 16'h0},
    '{1'b1, REG_LP_FB,  60'h7FFFF_80000, 16'h0, 1'b0, 1'b0, 16'h0},
    '{1'b1, REG_BP_FF,  60'hF0000_00000_10000, 16'h0, 1'b0, 1'b0, 16'h0},
    '{1'b1, REG_BP_FB,  60'h20000_C0000, 16'h0, 1'b0, 1'b0, 16'h0},
    '{1'b1, REG_HP_FF,  60'h40000_80000_40000, 16'h0, 1'b0, 1'b0, 16'h0},
    '{1'b1, REG_HP_FB,  60'h0, 16'h0, 1'b0, 1'b0, 16'h0},
    '{1'b1, REG_GAINS,  60'h1000_8000_7FFF, 16'h0, 1'b0, 1'b0, 16'h0},
    '{1'b0, REG_LP_FF,  60'h0, 16'h7FFF, 1'b0, 1'b0, 16'h0},
    '{1'b0, REG_LP_FF,  60'h0, 16'h7FFF, 1'b0, 1'b0, 16'h0},
    '{1'b0, REG_LP_FF,  60'h0, 16'h7FFF, 1'b0, 1'b0, 16'h0},
    '{1'b0, REG_LP_FF,  60'h0, 16'h8000, 1'b1, 1'b0, 16'h0},
    '{1'b0, REG_LP_FF,  60'h0, 16'h1234, 1'b1, 1'b0, 16'h0},
    '{1'b0, REG_LP_FF,  60'h0, 16'h7FFF, 1'b0, 1'b0, 16'h0},
    '{1'b0, REG_LP_FF,  60'h0, 16'h8000, 1'b0, 1'b0, 16'h0},
    '{1'b0, REG_LP_FF,  60'h0, 16'hFFFF, 1'b1, 1'b0, 16'h0},
    // low band alone, fed silence from saturated histories
    '{1'b1, REG_GAINS,  60'h0000_0000_1000, 16'h0, 1'b0, 1'b0, 16'h0},
    '{1'b0, REG_LP_FF,  60'h0, 16'h0000, 1'b0, 1'b0, 16'h0},
    '{1'b0, REG_LP_FF,  60'h0, 16'h0000, 1'b1, 1'b0, 16'h0}
  };

  localparam logic [REG_IDX_W-1:0] ALL_REGS [8] = '{
    REG_LP_FF, REG_LP_FB, REG_BP_FF, REG_BP_FB, REG_HP_FF, REG_HP_FB, REG_GAINS, REG_MASTER
  };

  typedef struct packed {
    logic [SAMPLE_W-1:0] smp;
    logic                ch;
  } eq_out_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [SAMPLE_W-1:0]  s_axis_tdata;   // [15:0] sample_in
  logic                 s_axis_tuser;   // [0] channel
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [SAMPLE_W-1:0]  m_axis_tdata;   // [15:0] sample_out
  logic                 m_axis_tuser;   // [0] channel_out
  logic                 cfg_we_i;
  logic [REG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  // equalised samples still to come, oldest first
  eq_out_t due_q[$];

  // predictor copy of the registers and filter histories
  logic [FF_W-1:0]    ff_coef [NUM_BANDS];
  logic [FB_W-1:0]    fb_coef [NUM_BANDS];
  logic [GAINS_W-1:0] band_gain;
  logic [GAIN_W-1:0]  master_gain;
  longint             x_hist [CHANNELS][2];
  longint             y_hist [CHANNELS][NUM_BANDS][2];

  int errors;
  int outputs_seen;
  int quiet;
  int burst_left;

  three_band_biquad_equalizer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // signed field k of width w
  function automatic longint sfield(logic [CFG_W-1:0] r, int k, int w);
    longint t;
    t = longint'((64'(r) >> (k * w)) & ((64'd1 << w) - 64'd1));
    if (t[w-1]) t = t - (longint'(1) << w);
    return t;
  endfunction

  function automatic longint round_sat(longint v, int sh, int w);
    longint hi, r;
    hi = (longint'(1) <<< (w - 1)) - 1;
    r  = (v + (longint'(1) <<< (sh - 1))) >>> sh;
    if (r > hi) r = hi;
    else if (r < -hi - 1) r = -hi - 1;
    return r;
  endfunction

  function automatic eq_out_t equalise(logic [SAMPLE_W-1:0] smp, logic ch);
    longint  x, acc, y, mix;
    int      c;
    eq_out_t o;
    c   = int'(ch) % CHANNELS;
    x   = sfield(CFG_W'(smp), 0, SAMPLE_W);
    mix = x <<< GAIN_FRAC;
    for (int b = 0; b < NUM_BANDS; b++) begin
      acc = sfield(ff_coef[b], 0, COEF_W) * x
          + sfield(ff_coef[b], 1, COEF_W) * x_hist[c][0]
          + sfield(ff_coef[b], 2, COEF_W) * x_hist[c][1]
          - sfield(CFG_W'(fb_coef[b]), 0, COEF_W) * y_hist[c][b][0]
          - sfield(CFG_W'(fb_coef[b]), 1, COEF_W) * y_hist[c][b][1];
      y = round_sat(acc, COEF_FRAC, BAND_W);
      y_hist[c][b][1] = y_hist[c][b][0];
      y_hist[c][b][0] = y;
      mix += sfield(CFG_W'(band_gain), b, GAIN_W) * y;
    end
    x_hist[c][1] = x_hist[c][0];
    x_hist[c][0] = x;
    o.smp = SAMPLE_W'(round_sat(mix * sfield(CFG_W'(master_gain), 0, GAIN_W),
                                2 * GAIN_FRAC, SAMPLE_W));
    o.ch  = ch;
    return o;
  endfunction

  function automatic logic [COEF_W-1:0] tame_coef(int unsigned span);
    return COEF_W'($urandom_range(0, 2 * span) - span);
  endfunction

  function automatic logic [CFG_W-1:0] setting_value(setting_e mode,
                                                     logic [REG_IDX_W-1:0] idx);
    if (mode == SET_RANDOM) return CFG_W'({$urandom, $urandom});
    case (idx)
      REG_LP_FF, REG_BP_FF, REG_HP_FF: begin
        case (mode)
          SET_MAX: return {3{20'h7FFFF}};
          SET_MIN: return {3{20'h80000}};
          default: return {tame_coef(1 << 17), tame_coef(1 << 17), tame_coef(1 << 17)};
        endcase
      end
      REG_LP_FB, REG_BP_FB, REG_HP_FB: begin
        case (mode)
          SET_MAX: return CFG_W'({2{20'h7FFFF}});
          SET_MIN: return CFG_W'({2{20'h80000}});
          default: return CFG_W'({tame_coef(1 << 16), tame_coef(1 << 17)});
        endcase
      end
      REG_GAINS: begin
        case (mode)
          SET_MAX: return CFG_W'({3{16'h7FFF}});
          SET_MIN: return CFG_W'({3{16'h8000}});
          default: return CFG_W'({GAIN_W'(tame_coef(8192)), GAIN_W'(tame_coef(8192)),
                                  GAIN_W'(tame_coef(8192))});
        endcase
      end
      default: begin
        // master gain
        case (mode)
          SET_MAX: return CFG_W'(16'h7FFF);
          SET_MIN: return CFG_W'(16'h8000);
          default: return CFG_W'(GAIN_W'(tame_coef(8192)));
        endcase
      end
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       return 16'h7FFF;
          1:       return 16'h8000;
          2:       return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      1:       return SAMPLE_W'($urandom_range(0, 512) - 256);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    // two registers per band
    case (idx)
      REG_LP_FF, REG_BP_FF, REG_HP_FF: ff_coef[idx >> 1] = val;
      REG_LP_FB, REG_BP_FB, REG_HP_FB: fb_coef[idx >> 1] = val[FB_W-1:0];
      REG_GAINS:                       band_gain = val[GAINS_W-1:0];
      default:                         master_gain = val[GAIN_W-1:0];
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // stop offering and let every outstanding result come out
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (due_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_item(logic [SAMPLE_W-1:0] smp, logic ch, logic typed,
                           logic [SAMPLE_W-1:0] want);
    eq_out_t o;
    int      gap;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tuser  <= ch;
    do @(posedge clk_i); while (!s_axis_tready);
    o = equalise(smp, ch);
    if (typed) o.smp = want;
    due_q.push_back(o);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_LP_FF;
    cfg_data_i    = '0;
    errors        = 0;
    burst_left    = 0;
    for (int b = 0; b < NUM_BANDS; b++) begin
      ff_coef[b] = '0;
      fb_coef[b] = '0;
    end
    band_gain   = '0;
    master_gain = MASTER_RST;
    for (int c = 0; c < CHANNELS; c++) begin
      x_hist[c][0] = 0;
      x_hist[c][1] = 0;
      for (int b = 0; b < NUM_BANDS; b++) begin
        y_hist[c][b][0] = 0;
        y_hist[c][b][1] = 0;
      end
    end
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIR_N; i++) begin
      if (DIR_ROWS[i].wr) begin
        drain();
        write_reg(DIR_ROWS[i].idx, DIR_ROWS[i].val);
      end else begin
        send_item(DIR_ROWS[i].smp, DIR_ROWS[i].ch, DIR_ROWS[i].typed, DIR_ROWS[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      for (int r = 0; r < 8; r++) write_reg(ALL_REGS[r], setting_value(PHASE_PLAN[p], ALL_REGS[r]));
      repeat (PHASE_ITEMS) send_item(rand_sample(), 1'($urandom_range(0, 1)), 1'b0, '0);
    end

    drain();
    repeat (48) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // receiver: random stall pattern, plus one long hold to back the block up
  initial begin
    int len;
    int style;
    bit held_long;
    m_axis_tready = 1'b0;
    held_long     = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held_long && outputs_seen >= 40) begin
        held_long = 1'b1;
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
      end else begin
        style = $urandom_range(0, 9);
        len   = $urandom_range(4, 48);
        repeat (len) begin
          @(negedge clk_i);
          if (style < 4) m_axis_tready <= 1'b1;
          else if (style < 8) m_axis_tready <= 1'($urandom_range(0, 1));
          else m_axis_tready <= 1'b0;
        end
      end
    end
  end

  initial outputs_seen = 0;

  always @(posedge clk_i) begin : check_output
    eq_out_t exp_o;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      outputs_seen++;
      if (due_q.size() == 0) begin
        $error("unexpected result: sample_out %0d channel_out %0d",
               $signed(m_axis_tdata), m_axis_tuser);
        errors++;
      end else begin
        exp_o = due_q.pop_front();
        if (m_axis_tdata !== exp_o.smp) begin
          $error("sample_out: expected %0d, got %0d", $signed(exp_o.smp),
                 $signed(m_axis_tdata));
          errors++;
        end
        if (m_axis_tuser !== exp_o.ch) begin
          $error("channel_out: expected %0d, got %0d", exp_o.ch, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  // watchdog: give up after a long run of cycles with no handshake on either side
  initial quiet = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule

@@ files.f @@
design/tbeq_pkg.sv
design/tbeq_ram.sv
design/tbeq_seq.sv
design/tbeq_dp.sv
design/three_band_biquad_equalizer.sv
bench/tb.sv
